[sv/tilt_compass_heading_core_defines.svh]
// Assertion helpers for the heading core
`ifndef TILT_COMPASS_HEADING_CORE_DEFINES_SVH
`define TILT_COMPASS_HEADING_CORE_DEFINES_SVH

// cons must hold in the same cycle as ante
`define TCH_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// cons must hold in the cycle after ante
`define TCH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[sv/tch_pkg.sv]
`timescale 1ns / 1ps

package tch_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CAL_W      = 16;
    localparam int EAST_W     = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_X,
        REG_MIN_Y,
        REG_MIN_Z,
        REG_MAX_X,
        REG_MAX_Y,
        REG_MAX_Z,
        REG_CAL_VALID,
        REG_SENSORS
    } cfg_reg_t;

    localparam int          CAL_SPAN        = 2000;
    localparam logic [1:0]  BOTH_SENSORS    = 2'd3;
    localparam int          MAG_PRESENT_BIT = 0;

    localparam int CORDIC_STEPS = 28;
    localparam int CORDIC_PRE   = 24;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
    localparam int CROSS_LAT    = 2;

    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005
    };

    typedef struct packed {
        logic signed [CAL_W-1:0] lo;
        logic signed [CAL_W-1:0] hi;
        logic                    cal_valid;
    } lane_cfg_t;

    // raw minus center; center lies between the bounds, within +-2^15
    function automatic int diff_w(input int sb);
        return ((sb > 18) ? sb : 18) + 1;
    endfunction

    // diff times 2000 (< 2^11)
    function automatic int num_w(input int sb);
        return diff_w(sb) + 11;
    endfunction

    function automatic int cal_latency(input int sb);
        return num_w(sb) + 4;
    endfunction

endpackage

[sv/tch_if.sv]
`timescale 1ns / 1ps

interface tch_sample_if #(parameter int SB = 16);
    logic                 valid;
    logic                 ready;
    logic signed [SB-1:0] mag_x;
    logic signed [SB-1:0] mag_y;
    logic signed [SB-1:0] mag_z;
    logic signed [SB-1:0] acc_x;
    logic signed [SB-1:0] acc_y;
    logic signed [SB-1:0] acc_z;

    modport source (output valid, mag_x, mag_y, mag_z, acc_x, acc_y, acc_z, input ready);
    modport sink (input valid, mag_x, mag_y, mag_z, acc_x, acc_y, acc_z, output ready);
endinterface

interface tch_result_if #(parameter int SB = 16, parameter int HB = 16);
    logic                 valid;
    logic                 ready;
    logic signed [SB-1:0] cal_mag_x;
    logic signed [SB-1:0] cal_mag_y;
    logic signed [SB-1:0] cal_mag_z;
    logic signed [31:0]   east_x;
    logic signed [31:0]   east_y;
    logic signed [31:0]   east_z;
    logic [HB-1:0]        heading;
    logic                 heading_valid;

    modport source (output valid, cal_mag_x, cal_mag_y, cal_mag_z, east_x, east_y, east_z,
                    heading, heading_valid, input ready);
    modport sink (input valid, cal_mag_x, cal_mag_y, cal_mag_z, east_x, east_y, east_z,
                  heading, heading_valid, output ready);
endinterface

interface tch_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [tch_pkg::CFG_IDX_W-1:0]     index;
    logic [tch_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[sv/tch_cal_lane.sv]
`timescale 1ns / 1ps

module tch_cal_lane #(
    parameter int SB = 16
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [SB-1:0]  raw,
    input  tch_pkg::lane_cfg_t    cfg,
    output logic signed [SB-1:0]  cal
);

    localparam int DIFW = tch_pkg::diff_w(SB);
    localparam int NUMW = tch_pkg::num_w(SB);
    localparam logic signed [NUMW-1:0] SCALE   = NUMW'(tch_pkg::CAL_SPAN);
    localparam logic [NUMW-1:0]        TOP_MAG = NUMW'((1 << (SB - 1)) - 1);
    localparam logic signed [SB-1:0]   SAT_HI  = SB'((1 << (SB - 1)) - 1);
    localparam logic signed [SB-1:0]   SAT_LO  = $signed({1'b1, {(SB - 1){1'b0}}});

    logic signed [16:0]     span_c;
    logic signed [16:0]     half_c;
    logic signed [17:0]     cen_c;
    logic signed [16:0]     span0_reg;
    logic signed [17:0]     cen0_reg;
    logic signed [SB-1:0]   raw0_reg;

    logic signed [DIFW-1:0] diff_c;
    logic signed [NUMW-1:0] num_c;
    logic signed [NUMW-1:0] num1_reg;
    logic signed [16:0]     span1_reg;
    logic signed [SB-1:0]   raw1_reg;

    logic [NUMW-1:0]        nm_c;
    logic [15:0]            dm_c;

    logic [NUMW-1:0]        nm_q   [NUMW+1];
    logic [15:0]            dm_q   [NUMW+1];
    logic [15:0]            rem_q  [NUMW+1];
    logic [NUMW-1:0]        quo_q  [NUMW+1];
    logic                   neg_q  [NUMW+1];
    logic                   zero_q [NUMW+1];
    logic signed [SB-1:0]   raw_q  [NUMW+1];

    logic [NUMW-1:0]        qm_c;
    logic signed [SB-1:0]   sat_c;
    logic signed [SB-1:0]   cal_reg;

    // span and center, halving truncates toward zero
    always_comb
    begin
        span_c = 17'(cfg.hi) - 17'(cfg.lo);
        half_c = (span_c + $signed({16'd0, span_c[16]})) >>> 1;
        cen_c  = 18'(half_c) + 18'(cfg.lo);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            span0_reg <= span_c;
            cen0_reg  <= cen_c;
            raw0_reg  <= raw;
        end
    end

    always_comb
    begin
        diff_c = DIFW'(raw0_reg) - DIFW'(cen0_reg);
        num_c  = NUMW'(diff_c) * SCALE;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num1_reg  <= num_c;
            span1_reg <= span0_reg;
            raw1_reg  <= raw0_reg;
        end
    end

    // sign-magnitude split for the unsigned divider
    always_comb
    begin
        nm_c = num1_reg[NUMW-1] ? NUMW'(-num1_reg) : NUMW'(num1_reg);
        dm_c = span1_reg[16] ? 16'(-span1_reg) : 16'(span1_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nm_q[0]   <= nm_c;
            dm_q[0]   <= dm_c;
            rem_q[0]  <= '0;
            quo_q[0]  <= '0;
            neg_q[0]  <= num1_reg[NUMW-1] ^ span1_reg[16];
            zero_q[0] <= (span1_reg == '0);
            raw_q[0]  <= raw1_reg;
        end
    end

    // one quotient bit per stage
    genvar k;
    generate
        for (k = 0; k < NUMW; k++)
        begin : g_div
            logic [16:0] trial_c;
            logic        ge_c;

            always_comb
            begin
                trial_c = {rem_q[k], nm_q[k][NUMW-1]};
                ge_c    = (trial_c >= {1'b0, dm_q[k]});
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_q[k+1]  <= ge_c ? 16'(trial_c - {1'b0, dm_q[k]}) : trial_c[15:0];
                    quo_q[k+1]  <= {quo_q[k][NUMW-2:0], ge_c};
                    nm_q[k+1]   <= nm_q[k] << 1;
                    dm_q[k+1]   <= dm_q[k];
                    neg_q[k+1]  <= neg_q[k];
                    zero_q[k+1] <= zero_q[k];
                    raw_q[k+1]  <= raw_q[k];
                end
            end
        end
    endgenerate

    always_comb
    begin
        qm_c = quo_q[NUMW];
        if (zero_q[NUMW])
            sat_c = '0;
        else if (neg_q[NUMW])
            sat_c = (qm_c > TOP_MAG + 1'b1) ? SAT_LO : -$signed(SB'(qm_c));
        else
            sat_c = (qm_c > TOP_MAG) ? SAT_HI : $signed(SB'(qm_c));
    end

    always_ff @(posedge clk)
    begin
        if (en)
            cal_reg <= cfg.cal_valid ? sat_c : raw_q[NUMW];
    end

    assign cal = cal_reg;

endmodule

[sv/tch_cordic.sv]
`timescale 1ns / 1ps

module tch_cordic #(
    parameter int HB = 16
) (
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] x,
    input  logic signed [31:0] y,
    output logic [HB-1:0]      heading
);

    localparam int N  = tch_pkg::CORDIC_STEPS;
    localparam int CW = 33 + tch_pkg::CORDIC_PRE + 2;
    localparam logic [31:0] HALF_TURN = 32'h8000_0000;
    localparam logic [31:0] ROUND     = 32'(1) << (31 - HB);

    logic signed [32:0]   xa_c;
    logic signed [32:0]   ya_c;
    logic signed [CW-1:0] xq    [N+1];
    logic signed [CW-1:0] yq    [N+1];
    logic [31:0]          zq    [N+1];
    logic                 zero_q[N+1];
    logic [31:0]          zr_c;
    logic [HB-1:0]        heading_reg;

    // fold into right half-plane
    always_comb
    begin
        xa_c = x[31] ? -33'(x) : 33'(x);
        ya_c = x[31] ? -33'(y) : 33'(y);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xq[0]     <= $signed({{(CW - 33 - tch_pkg::CORDIC_PRE){xa_c[32]}}, xa_c,
                                  {tch_pkg::CORDIC_PRE{1'b0}}});
            yq[0]     <= $signed({{(CW - 33 - tch_pkg::CORDIC_PRE){ya_c[32]}}, ya_c,
                                  {tch_pkg::CORDIC_PRE{1'b0}}});
            zq[0]     <= x[31] ? HALF_TURN : '0;
            zero_q[0] <= (x == '0) && (y == '0);
        end
    end

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_iter
            logic signed [CW-1:0] xs_c;
            logic signed [CW-1:0] ys_c;

            always_comb
            begin
                xs_c = xq[i] >>> i;
                ys_c = yq[i] >>> i;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (!yq[i][CW-1])
                    begin
                        xq[i+1] <= xq[i] + ys_c;
                        yq[i+1] <= yq[i] - xs_c;
                        zq[i+1] <= zq[i] + tch_pkg::ATAN_TURNS[i];
                    end
                    else
                    begin
                        xq[i+1] <= xq[i] - ys_c;
                        yq[i+1] <= yq[i] + xs_c;
                        zq[i+1] <= zq[i] - tch_pkg::ATAN_TURNS[i];
                    end
                    zero_q[i+1] <= zero_q[i];
                end
            end
        end
    endgenerate

    assign zr_c = zq[N] + ROUND;

    always_ff @(posedge clk)
    begin
        if (en)
            heading_reg <= zero_q[N] ? '0 : zr_c[31 -: HB];
    end

    assign heading = heading_reg;

endmodule

[sv/tilt_compass_heading_core.sv]
// Path: sample accept, the calibration lanes (one-bit-per-stage divider in each lane),
//       the cross product, the CORDIC, then the result register.
// Throughput: one word per cycle while the skid register is empty; the result register
//             plus a skid register keep the input open while one finished word waits.
// Reset (rst_n low, async): config registers clear to 0, all valid bits clear;
//                           datapath registers are not reset.
`timescale 1ns / 1ps
`include "tilt_compass_heading_core_defines.svh"

module tilt_compass_heading_core #(
    parameter int SAMPLE_BITS  = 16,
    parameter int HEADING_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    tch_sample_if.sink    sample,
    tch_result_if.source  result,
    tch_cfg_if.sink       cfg
);

    localparam int SB      = SAMPLE_BITS;
    localparam int PW      = 2 * SB;
    localparam int EXW     = (PW + 1 > 32) ? PW + 1 : 32;
    localparam int L_CAL   = tch_pkg::cal_latency(SB);
    localparam int MAG_LAT = tch_pkg::CROSS_LAT + tch_pkg::CORDIC_LAT;
    localparam int TOTAL   = L_CAL + MAG_LAT;

    typedef struct packed {
        logic signed [SB-1:0] x;
        logic signed [SB-1:0] y;
        logic signed [SB-1:0] z;
    } vec_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } east_t;

    typedef struct packed {
        logic signed [SB-1:0]    cal_mag_x;
        logic signed [SB-1:0]    cal_mag_y;
        logic signed [SB-1:0]    cal_mag_z;
        logic signed [31:0]      east_x;
        logic signed [31:0]      east_y;
        logic signed [31:0]      east_z;
        logic [HEADING_BITS-1:0] heading;
        logic                    heading_valid;
    } res_t;

    // configuration
    logic signed [tch_pkg::CAL_W-1:0] cal_min_reg [3];
    logic signed [tch_pkg::CAL_W-1:0] cal_max_reg [3];
    logic                             cal_valid_reg;
    logic [1:0]                       present_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                cal_min_reg[a] <= '0;
                cal_max_reg[a] <= '0;
            end
            cal_valid_reg <= 1'b0;
            present_reg   <= '0;
        end
        else if (cfg.valid)
        begin
            case (tch_pkg::cfg_reg_t'(cfg.index))
                tch_pkg::REG_MIN_X:     cal_min_reg[0] <= $signed(cfg.data);
                tch_pkg::REG_MIN_Y:     cal_min_reg[1] <= $signed(cfg.data);
                tch_pkg::REG_MIN_Z:     cal_min_reg[2] <= $signed(cfg.data);
                tch_pkg::REG_MAX_X:     cal_max_reg[0] <= $signed(cfg.data);
                tch_pkg::REG_MAX_Y:     cal_max_reg[1] <= $signed(cfg.data);
                tch_pkg::REG_MAX_Z:     cal_max_reg[2] <= $signed(cfg.data);
                tch_pkg::REG_CAL_VALID: cal_valid_reg  <= cfg.data[0];
                tch_pkg::REG_SENSORS:   present_reg    <= cfg.data[1:0];
                default: ;
            endcase
        end
    end

    assign cfg.ready = 1'b1;

    // pipeline control: whole pipe moves unless the skid register is holding a word
    logic             en;
    logic             accept;
    logic [TOTAL-1:0] vpipe_reg;
    logic             pipe_done;
    logic             skid_valid_reg;

    assign en           = !skid_valid_reg;
    assign sample.ready = en;
    assign accept       = sample.valid && en;
    assign pipe_done    = vpipe_reg[TOTAL-1] && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vpipe_reg <= '0;
        else if (en)
            vpipe_reg <= {vpipe_reg[TOTAL-2:0], accept};
    end

    // calibration lanes
    logic signed [SB-1:0] raw_c  [3];
    logic signed [SB-1:0] cal_c  [3];
    tch_pkg::lane_cfg_t   lcfg_c [3];

    assign raw_c[0] = sample.mag_x;
    assign raw_c[1] = sample.mag_y;
    assign raw_c[2] = sample.mag_z;

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_lane
            assign lcfg_c[g] = '{lo: cal_min_reg[g], hi: cal_max_reg[g],
                                 cal_valid: cal_valid_reg};

            tch_cal_lane #(.SB(SB)) u_lane (
                .clk (clk),
                .en  (en),
                .raw (raw_c[g]),
                .cfg (lcfg_c[g]),
                .cal (cal_c[g])
            );
        end
    endgenerate

    // accelerometer rides alongside the lanes
    vec_t acc_dly_reg [L_CAL];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_dly_reg[0] <= '{x: sample.acc_x, y: sample.acc_y, z: sample.acc_z};
            for (int a = 1; a < L_CAL; a++)
                acc_dly_reg[a] <= acc_dly_reg[a-1];
        end
    end

    // merge: cross product of the three lanes with the accelerometer
    vec_t                 mag_c;
    vec_t                 acc_c;
    logic signed [PW-1:0] prod_reg [6];
    east_t                east_c;
    east_t                east_reg;
    logic signed [EXW-1:0] ex_c;
    logic signed [EXW-1:0] ey_c;
    logic signed [EXW-1:0] ez_c;

    assign mag_c = present_reg[tch_pkg::MAG_PRESENT_BIT]
                 ? vec_t'{cal_c[0], cal_c[1], cal_c[2]} : '0;
    assign acc_c = acc_dly_reg[L_CAL-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg[0] <= mag_c.y * acc_c.z;
            prod_reg[1] <= mag_c.z * acc_c.y;
            prod_reg[2] <= mag_c.z * acc_c.x;
            prod_reg[3] <= mag_c.x * acc_c.z;
            prod_reg[4] <= mag_c.x * acc_c.y;
            prod_reg[5] <= mag_c.y * acc_c.x;
        end
    end

    // components wrap to 32 bits
    always_comb
    begin
        ex_c     = EXW'(prod_reg[0]) - EXW'(prod_reg[1]);
        ey_c     = EXW'(prod_reg[2]) - EXW'(prod_reg[3]);
        ez_c     = EXW'(prod_reg[4]) - EXW'(prod_reg[5]);
        east_c.x = $signed(ex_c[31:0]);
        east_c.y = $signed(ey_c[31:0]);
        east_c.z = $signed(ez_c[31:0]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            east_reg <= east_c;
    end

    logic [HEADING_BITS-1:0] heading_c;

    tch_cordic #(.HB(HEADING_BITS)) u_cordic (
        .clk     (clk),
        .en      (en),
        .x       (east_reg.x),
        .y       (east_reg.y),
        .heading (heading_c)
    );

    vec_t  mag_dly_reg  [MAG_LAT];
    east_t east_dly_reg [tch_pkg::CORDIC_LAT];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_dly_reg[0] <= mag_c;
            for (int a = 1; a < MAG_LAT; a++)
                mag_dly_reg[a] <= mag_dly_reg[a-1];
            east_dly_reg[0] <= east_reg;
            for (int a = 1; a < tch_pkg::CORDIC_LAT; a++)
                east_dly_reg[a] <= east_dly_reg[a-1];
        end
    end

    // final word
    res_t  res_c;
    logic  both_c;
    east_t east_last_c;
    vec_t  mag_last_c;

    always_comb
    begin
        both_c      = (present_reg == tch_pkg::BOTH_SENSORS);
        east_last_c = east_dly_reg[tch_pkg::CORDIC_LAT-1];
        mag_last_c  = mag_dly_reg[MAG_LAT-1];
        res_c.cal_mag_x     = mag_last_c.x;
        res_c.cal_mag_y     = mag_last_c.y;
        res_c.cal_mag_z     = mag_last_c.z;
        res_c.east_x        = both_c ? east_last_c.x : '0;
        res_c.east_y        = both_c ? east_last_c.y : '0;
        res_c.east_z        = both_c ? east_last_c.z : '0;
        res_c.heading       = both_c ? heading_c : '0;
        res_c.heading_valid = both_c;
    end

    // output register with skid
    res_t out_reg;
    res_t skid_reg;
    logic out_valid_reg;
    logic out_valid_next;
    logic skid_valid_next;
    logic take;
    logic out_from_skid;
    logic out_from_pipe;
    logic skid_load;
    logic out_clear_c;

    assign take = out_valid_reg && result.ready;

    always_comb
    begin
        out_from_skid   = take && skid_valid_reg;
        out_from_pipe   = pipe_done && (take || !out_valid_reg);
        skid_load       = pipe_done && out_valid_reg && !take;
        out_valid_next  = out_from_skid || out_from_pipe || (out_valid_reg && !take);
        skid_valid_next = skid_load || (skid_valid_reg && !take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_from_skid)
            out_reg <= skid_reg;
        else if (out_from_pipe)
            out_reg <= res_c;
        if (skid_load)
            skid_reg <= res_c;
    end

    assign result.valid         = out_valid_reg;
    assign result.cal_mag_x     = out_reg.cal_mag_x;
    assign result.cal_mag_y     = out_reg.cal_mag_y;
    assign result.cal_mag_z     = out_reg.cal_mag_z;
    assign result.east_x        = out_reg.east_x;
    assign result.east_y        = out_reg.east_y;
    assign result.east_z        = out_reg.east_z;
    assign result.heading       = out_reg.heading;
    assign result.heading_valid = out_reg.heading_valid;

    assign out_clear_c = (out_reg.heading == '0) && (out_reg.east_x == '0)
                      && (out_reg.east_y == '0) && (out_reg.east_z == '0);

    `TCH_ASSERT_SAME(a_skid_needs_out, skid_valid_reg, out_valid_reg)
    `TCH_ASSERT_NEXT(a_skid_drains, skid_valid_reg && result.ready, out_valid_reg && !skid_valid_reg)
    `TCH_ASSERT_SAME(a_no_heading_zero, out_valid_reg && !out_reg.heading_valid, out_clear_c)

endmodule
